>>> sv/pvfc_pkg.sv
// Shared types and constants for the clamped velocity-form PID controller.
// Used by pid_velocity_form_clamped; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pvfc_pkg;

  // Field widths.
  localparam int SP_W    = 16;
  localparam int MEAS_W  = 16;
  localparam int GAIN_W  = 8;
  localparam int LIM_W   = 10;
  localparam int ACC_W   = 18;
  localparam int FRAC_W  = 8;
  localparam int DIFF_W  = MEAS_W + 1;  // first difference of the measurement
  localparam int DIFF2_W = MEAS_W + 3;  // second difference of the measurement
  localparam int ERR_W   = SP_W + 2;    // setpoint minus measurement
  // Width of every term and of the summed update; all terms stay well below 2^32.
  localparam int SUM_W   = 34;

  // Configuration port.
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_OUT_MAX = 3'd3,
    REG_OUT_MIN = 3'd4
  } reg_idx_t;

  // Register reset values.
  localparam logic [GAIN_W-1:0] GAIN_P_RST  = 8'd20;
  localparam logic [GAIN_W-1:0] GAIN_I_RST  = 8'd22;
  localparam logic [GAIN_W-1:0] GAIN_D_RST  = 8'd20;
  localparam logic [LIM_W-1:0]  OUT_MAX_RST = 10'd100;
  localparam logic [LIM_W-1:0]  OUT_MIN_RST = 10'd0;

  // Multiply a signed term by ten with two shifts and an add.
  function automatic logic signed [SUM_W-1:0] times_ten(input logic signed [SUM_W-1:0] x);
    return (x <<< 3) + (x <<< 1);
  endfunction

endpackage

`default_nettype wire

>>> sv/pid_velocity_form_clamped.sv
// Clamped velocity-form PID controller with a 10.8 fixed-point drive accumulator,
// built as three register stages plus an APB register file; uses pvfc_pkg.
// Each accepted item passes through stages A, B and C; throughput is one item per cycle
// unless the result stalls, since the accumulator loop is one add and clamp in the last
// stage; a stalled result holds each stage in turn until all three fill.
// Synchronous reset empties the pipeline, zeroes the state and restores the defaults.
`timescale 1ns / 1ps
`default_nettype none

module pid_velocity_form_clamped (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input items.
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [31:0]                   s_tdata,   // [15:0] setpoint, [31:16] measured
  // Result items.
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [15:0]                        m_tdata,   // [9:0] drive, [15:10] zero
  // Configuration.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pvfc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pvfc_pkg::DATA_W-1:0]   pwdata,
  output logic [pvfc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int SW = pvfc_pkg::SUM_W;

  // ---------------------------------------------------------------- registers
  logic [pvfc_pkg::GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic [pvfc_pkg::LIM_W-1:0]  out_max, out_min;
  pvfc_pkg::reg_idx_t          reg_idx;
  logic                        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = pvfc_pkg::reg_idx_t'(paddr[pvfc_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p  <= pvfc_pkg::GAIN_P_RST;
      gain_i  <= pvfc_pkg::GAIN_I_RST;
      gain_d  <= pvfc_pkg::GAIN_D_RST;
      out_max <= pvfc_pkg::OUT_MAX_RST;
      out_min <= pvfc_pkg::OUT_MIN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        pvfc_pkg::REG_GAIN_P:  gain_p  <= pwdata[pvfc_pkg::GAIN_W-1:0];
        pvfc_pkg::REG_GAIN_I:  gain_i  <= pwdata[pvfc_pkg::GAIN_W-1:0];
        pvfc_pkg::REG_GAIN_D:  gain_d  <= pwdata[pvfc_pkg::GAIN_W-1:0];
        pvfc_pkg::REG_OUT_MAX: out_max <= pwdata[pvfc_pkg::LIM_W-1:0];
        pvfc_pkg::REG_OUT_MIN: out_min <= pwdata[pvfc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pvfc_pkg::REG_GAIN_P:  prdata = {24'd0, gain_p};
      pvfc_pkg::REG_GAIN_I:  prdata = {24'd0, gain_i};
      pvfc_pkg::REG_GAIN_D:  prdata = {24'd0, gain_d};
      pvfc_pkg::REG_OUT_MAX: prdata = {22'd0, out_max};
      pvfc_pkg::REG_OUT_MIN: prdata = {22'd0, out_min};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- flow control
  logic a_valid, b_valid, c_valid;
  logic ready_a, ready_b, ready_c;
  logic accept;

  assign ready_c  = !c_valid || m_tready;
  assign ready_b  = !b_valid || ready_c;
  assign ready_a  = !a_valid || ready_b;
  assign s_tready = ready_a;
  assign accept   = s_tvalid && ready_a;

  // ---------------------------------------------- stage A: differences
  logic [pvfc_pkg::SP_W-1:0]          sp_in;
  logic [pvfc_pkg::MEAS_W-1:0]        meas_in;
  logic [pvfc_pkg::MEAS_W-1:0]        prev_measured, prev2_measured;
  logic signed [pvfc_pkg::DIFF_W-1:0]  dm1_next, a_dm1;
  logic signed [pvfc_pkg::DIFF2_W-1:0] d2_next, a_d2;
  logic signed [pvfc_pkg::ERR_W-1:0]   err_next, a_err;
  logic                                a_clear;

  assign sp_in   = s_tdata[15:0];
  assign meas_in = s_tdata[31:16];

  assign dm1_next = $signed({meas_in[15], meas_in}) - $signed({prev_measured[15], prev_measured});
  // m - 2*m1 + m2, every operand sign-extended to the full width.
  assign d2_next  = $signed({{3{meas_in[15]}}, meas_in})
                  - $signed({{2{prev_measured[15]}}, prev_measured, 1'b0})
                  + $signed({{3{prev2_measured[15]}}, prev2_measured});
  assign err_next = $signed({2'b00, sp_in}) - $signed({{2{meas_in[15]}}, meas_in});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      prev_measured  <= '0;
      prev2_measured <= '0;
    end else begin
      if (ready_a) a_valid <= s_tvalid;
      if (accept) begin
        prev2_measured <= prev_measured;
        prev_measured  <= meas_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_dm1   <= dm1_next;
      a_d2    <= d2_next;
      a_err   <= err_next;
      a_clear <= (sp_in == '0);
    end
  end

  // ---------------------------------------------- stage B: gain products
  logic signed [25:0]   p_prod;
  logic signed [26:0]   i_prod, i_adj, i_half;
  logic signed [27:0]   d_prod;
  logic signed [SW-1:0] b_p10, b_i, b_d10;
  logic                 b_clear;

  assign p_prod = $signed({1'b0, gain_p}) * a_dm1;
  assign i_prod = $signed({1'b0, gain_i}) * a_err;
  assign d_prod = $signed({1'b0, gain_d}) * a_d2;
  // Halve with truncation toward zero: bias negative values by one before the shift.
  assign i_adj  = i_prod + $signed({26'd0, i_prod[26]});
  assign i_half = i_adj >>> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (ready_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && a_valid) begin
      b_p10   <= pvfc_pkg::times_ten(SW'(p_prod));
      b_i     <= SW'(i_half);
      // gain_d * d2 * 500 / 50 is exact, so it is simply times ten.
      b_d10   <= pvfc_pkg::times_ten(SW'(d_prod));
      b_clear <= a_clear;
    end
  end

  // --------------------------------------- stage C: accumulate and clamp
  logic [pvfc_pkg::ACC_W-1:0] accumulator, acc_next;
  logic [pvfc_pkg::LIM_W-1:0] drive;
  logic signed [SW-1:0]       sum, hi, lo, clamped;
  logic                       c_load;

  assign c_load = b_valid && ready_c;
  assign hi  = $signed({{(SW-pvfc_pkg::LIM_W-pvfc_pkg::FRAC_W){1'b0}}, out_max,
                        {pvfc_pkg::FRAC_W{1'b0}}});
  assign lo  = $signed({{(SW-pvfc_pkg::LIM_W-pvfc_pkg::FRAC_W){1'b0}}, out_min,
                        {pvfc_pkg::FRAC_W{1'b0}}});
  assign sum = $signed({{(SW-pvfc_pkg::ACC_W){1'b0}}, accumulator}) + b_i - b_p10 - b_d10;

  // Upper bound first, then lower, so the minimum wins when the limits cross.
  always_comb begin
    clamped = b_clear ? '0 : sum;
    if (clamped > hi) clamped = hi;
    if (clamped < lo) clamped = lo;
    acc_next = clamped[pvfc_pkg::ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid     <= 1'b0;
      accumulator <= '0;
    end else begin
      if (ready_c) c_valid <= b_valid;
      if (c_load) accumulator <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) drive <= acc_next[pvfc_pkg::ACC_W-1:pvfc_pkg::FRAC_W];
  end

  assign m_tvalid = c_valid;
  assign m_tdata  = {6'd0, drive};

`ifndef NO_ASSERTIONS
  // The result always shows the integer part of the stored accumulator.
  a_drive_matches_acc: assert property (@(posedge clk) disable iff (rst)
    c_load |=> (drive == accumulator[pvfc_pkg::ACC_W-1:pvfc_pkg::FRAC_W]))
    else $error("drive does not match accumulator");

  // A zero setpoint leaves the drive at the lower limit.
  a_clear_to_min: assert property (@(posedge clk) disable iff (rst)
    (c_load && b_clear) |=> (drive == $past(out_min)))
    else $error("cleared accumulator not at lower limit");

  // With ordered limits the drive lands inside them.
  a_in_range: assert property (@(posedge clk) disable iff (rst)
    (c_load && (out_min <= out_max)) |=> (drive <= $past(out_max) && drive >= $past(out_min)))
    else $error("drive outside limits");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !a_valid && !b_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

>>> test/pid_drive_checker.sv
// Scoreboard for the clamped velocity-form PID controller: watches the sample,
// drive and register channels, predicts each drive item and compares it.
// Depends on pvfc_pkg for widths and register indexes.
`timescale 1ns / 1ps

module pid_drive_checker
  import pvfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [31:0]       s_tdata,   // [15:0] setpoint, [31:16] measured
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [15:0]       m_tdata,   // [9:0] drive, [15:10] zero
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                mismatch_count,
  output int                drives_pending
);

  localparam longint P_SCALE  = 10;
  localparam longint D_SCALE  = 500;
  localparam longint SAMPLE_K = 50;
  localparam longint I_DIV    = 100;
  localparam longint FRAC_ONE = 256;

  logic [GAIN_W-1:0]        kp, ki, kd;
  logic [LIM_W-1:0]         lim_hi, lim_lo;
  longint                   acc;
  logic signed [MEAS_W-1:0] meas_z1, meas_z2;
  logic [LIM_W-1:0]         drive_queue[$];

  // Advances the controller by one sample and returns the drive it yields.
  function automatic logic [LIM_W-1:0] advance_loop(input logic [SP_W-1:0] sp,
                                                    input logic signed [MEAS_W-1:0] m);
    longint spv, mv, m1, m2, err, nxt, hi, lo;
    spv = sp;
    mv  = m;
    m1  = meas_z1;
    m2  = meas_z2;
    err = spv - mv;
    hi  = longint'(lim_hi) * FRAC_ONE;
    lo  = longint'(lim_lo) * FRAC_ONE;
    nxt = acc - longint'(kp) * (mv - m1) * P_SCALE;
    nxt = nxt + (longint'(ki) * err * SAMPLE_K) / I_DIV;
    nxt = nxt - (longint'(kd) * (mv - 2 * m1 + m2) * D_SCALE) / SAMPLE_K;
    meas_z2 = meas_z1;
    meas_z1 = m;
    if (spv == 0) nxt = 0;
    // The upper clamp goes first, so a minimum above the maximum wins.
    if (nxt > hi) nxt = hi;
    if (nxt < lo) nxt = lo;
    acc = nxt;
    return LIM_W'(acc >>> FRAC_W);
  endfunction

  always @(posedge clk) begin
    logic [LIM_W-1:0] want;
    if (rst) begin
      kp = GAIN_P_RST;
      ki = GAIN_I_RST;
      kd = GAIN_D_RST;
      lim_hi = OUT_MAX_RST;
      lim_lo = OUT_MIN_RST;
      acc = 0;
      meas_z1 = '0;
      meas_z2 = '0;
      drive_queue.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (drive_queue.size() == 0) begin
          $error("drive: no item waiting, expected none, actual %0d", m_tdata[LIM_W-1:0]);
          mismatch_count++;
        end else begin
          want = drive_queue.pop_front();
          if (m_tdata[LIM_W-1:0] !== want) begin
            $error("drive: expected %0d, actual %0d", want, m_tdata[LIM_W-1:0]);
            mismatch_count++;
          end
          if (m_tdata[15:LIM_W] !== '0) begin
            $error("pad: expected 0, actual %0h", m_tdata[15:LIM_W]);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        drive_queue.push_back(advance_loop(s_tdata[SP_W-1:0], s_tdata[31:SP_W]));
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_GAIN_P:  kp = pwdata[GAIN_W-1:0];
          REG_GAIN_I:  ki = pwdata[GAIN_W-1:0];
          REG_GAIN_D:  kd = pwdata[GAIN_W-1:0];
          REG_OUT_MAX: lim_hi = pwdata[LIM_W-1:0];
          REG_OUT_MIN: lim_lo = pwdata[LIM_W-1:0];
          default: ;
        endcase
      end
    end
    drives_pending = drive_queue.size();
  end

endmodule

>>> test/pid_velocity_form_clamped_test.sv
// Top of the testbench for pid_velocity_form_clamped: drives samples and register
// writes, stalls the drive side, and reports the verdict from pid_drive_checker.
// Depends on pvfc_pkg, pid_drive_checker and the block itself.
`timescale 1ns / 1ps

module pid_velocity_form_clamped_test;
  import pvfc_pkg::*;

  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          HOLD_CYCLES  = 60;
  localparam logic [2:0]  IDX_SPARE_LO = 3'd5;
  localparam logic [2:0]  IDX_SPARE_HI = 3'd7;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [31:0]       s_tdata;   // [15:0] setpoint, [31:16] measured
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;   // [9:0] drive, [15:10] zero
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                mismatch_count;
  int                drives_pending;
  bit                hold_request;
  int                cycle_count;
  int                meas_walk;

  pid_velocity_form_clamped i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pid_drive_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .mismatch_count, .drives_pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // The drive side switches between random stall patterns, and on request holds
  // off for a long stretch so that the pipeline fills up.
  initial begin
    int mode;
    m_tready = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (cycle_count % 32 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (cycle_count % 4 != 0);
        endcase
      end
    end
  end

  task automatic drive_item(input logic [SP_W-1:0] sp, input logic [MEAS_W-1:0] m);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {m, sp};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Waits until every drive item has come back, then lets the pipeline drain.
  task automatic wait_drained();
    idle_input(1);
    while (drives_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper bits of each value are filled with noise; the block keeps only its width.
  task automatic set_loop(input int gp, input int gi, input int gd, input int hi, input int lo);
    wait_drained();
    write_reg(REG_GAIN_P,  ($urandom << GAIN_W) | gp);
    write_reg(REG_GAIN_I,  ($urandom << GAIN_W) | gi);
    write_reg(REG_GAIN_D,  ($urandom << GAIN_W) | gd);
    write_reg(REG_OUT_MAX, ($urandom << LIM_W) | hi);
    write_reg(REG_OUT_MIN, ($urandom << LIM_W) | lo);
  endtask

  function automatic int pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 255;
    if (r == 2) return $urandom_range(0, 255);
    return $urandom_range(0, 8);
  endfunction

  // Mostly a slowly moving measurement with a nearby setpoint; the rest is noise
  // and zero setpoints.
  task automatic send_sample();
    int r, sp;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      drive_item('0, 16'($urandom));
    end else if (r < 30) begin
      drive_item(16'($urandom), 16'($urandom));
    end else begin
      meas_walk = meas_walk + $urandom_range(0, 40) - 20;
      if (meas_walk > 32767) meas_walk = 32767;
      if (meas_walk < -32768) meas_walk = -32768;
      sp = meas_walk + $urandom_range(0, 60) - 10;
      if (sp < 1) sp = 1;
      if (sp > 65535) sp = 65535;
      drive_item(16'(sp), 16'(meas_walk));
    end
  endtask

  task automatic random_phase(input int n_items, input bit long_hold);
    int sent, burst, gap, hi, lo;
    hi = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 1023 : 1000)
                                   : $urandom_range(1, 1023);
    lo = $urandom_range(0, 5) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, hi / 2);
    set_loop(pick_gain(), pick_gain(), pick_gain(), hi, lo);
    meas_walk = $urandom_range(0, 2000) - 1000;
    sent = 0;
    if (long_hold) begin
      @(posedge clk);
      hold_request = 1'b1;
      repeat (24) send_sample();
      sent = 24;
    end
    while (sent < n_items) begin
      burst = $urandom_range(0, 4) == 0 ? 40 : $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        send_sample();
        sent++;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      idle_input(gap);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_request = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default gains and limits, field extremes, and a zero setpoint.
    drive_item(16'h0000, 16'h0000);
    drive_item(16'hFFFF, 16'h7FFF);
    drive_item(16'hFFFF, 16'h8000);
    drive_item(16'h0000, 16'h8000);
    drive_item(16'h0001, 16'h0001);
    drive_item(16'd200, 16'd10);
    drive_item(16'd200, 16'd12);
    drive_item(16'h8000, 16'hFFFF);

    // Integral term only, widest upper limit.
    set_loop(0, 255, 0, 1023, 0);
    drive_item(16'd300, 16'd0);
    drive_item(16'd300, 16'd0);
    drive_item(16'hFFFF, 16'h8000);
    drive_item(16'h0000, 16'd5);

    // Largest proportional and derivative gains with the limits equal.
    set_loop(255, 0, 255, 1000, 1000);
    drive_item(16'd1000, 16'd100);
    drive_item(16'd1000, -16'sd100);
    drive_item(16'd1000, 16'h7FFF);

    // Minimum above maximum: the minimum wins.
    set_loop(20, 22, 20, 10, 50);
    drive_item(16'd500, 16'd0);
    drive_item(16'd0, 16'd0);
    drive_item(16'd1, 16'h8000);

    // Writes to unused indexes must leave the loop untouched.
    wait_drained();
    for (int idx = IDX_SPARE_LO; idx <= IDX_SPARE_HI; idx++) write_reg(3'(idx), $urandom);
    drive_item(16'd700, 16'd3);
    drive_item(16'd700, 16'd1);

    random_phase(72, 1'b0);
    random_phase(72, 1'b1);
    for (int p = 0; p < 6; p++) random_phase(72, 1'b0);

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && drives_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/pvfc_pkg.sv
sv/pid_velocity_form_clamped.sv
test/pid_drive_checker.sv
test/pid_velocity_form_clamped_test.sv
